[rtl/lav_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lav_pkg;

  localparam int WORD_W        = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam logic [1:0] ROW_LAST = 2'd3;

  // One queued direction/position word, already classified by the front end.
  typedef struct packed {
    logic [WORD_W-1:0] lx;
    logic [WORD_W-1:0] ly;
    logic [WORD_W-1:0] lz;
    logic [WORD_W-1:0] px;
    logic [WORD_W-1:0] py;
    logic [WORD_W-1:0] pz;
    logic              deg;
    logic [WORD_W-1:0] mh;
    logic [WORD_W-1:0] m3;
  } item_t;

  // A finished matrix handed from the back end to the row emitter.
  typedef struct packed {
    logic [WORD_W-1:0] rx;
    logic [WORD_W-1:0] rz;
    logic [WORD_W-1:0] ux;
    logic [WORD_W-1:0] uy;
    logic [WORD_W-1:0] uz;
    logic [WORD_W-1:0] lx;
    logic [WORD_W-1:0] ly;
    logic [WORD_W-1:0] lz;
    logic [WORD_W-1:0] t0;
    logic [WORD_W-1:0] t1;
    logic [WORD_W-1:0] t2;
    logic              deg;
  } bank_t;

  typedef enum logic [4:0] {
    S_IDLE, S_PRE, S_SQA, S_SQB, S_SQC, S_SQRT, S_HSQA, S_HSQB, S_HSQC,
    S_DIV, S_DRND, S_MX, S_MXB, S_MZ, S_MZB, S_TDOT, S_FIN, S_DONE
  } back_state_t;

  typedef enum logic [2:0] {
    DST_RX, DST_RZ, DST_UY, DST_UX, DST_UZ
  } div_dst_t;

  typedef enum logic [1:0] {
    SQ_N, SQ_H, SQ_D
  } sq_dst_t;

endpackage

`default_nettype wire

[rtl/lav_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module lav_front (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [lav_pkg::WORD_W-1:0] dir_x,
  input  wire logic [lav_pkg::WORD_W-1:0] dir_y,
  input  wire logic [lav_pkg::WORD_W-1:0] dir_z,
  input  wire logic [lav_pkg::WORD_W-1:0] pos_x,
  input  wire logic [lav_pkg::WORD_W-1:0] pos_y,
  input  wire logic [lav_pkg::WORD_W-1:0] pos_z,
  output logic                           push_valid,
  input  wire logic                      push_ready,
  output lav_pkg::item_t                 push_item
);
  import lav_pkg::*;

  function automatic logic [WORD_W-1:0] mag(input logic [WORD_W-1:0] v);
    mag = v[WORD_W-1] ? (~v + 1'b1) : v;
  endfunction

  logic              hold_valid;
  item_t             hold;
  item_t             cls;
  logic [WORD_W-1:0] ax, ay, az, mh;

  // The horizontal magnitude sets the right-vector scale, the full one the up-vector scale.
  always_comb begin
    ax  = mag(dir_x);
    ay  = mag(dir_y);
    az  = mag(dir_z);
    mh  = (ax > az) ? ax : az;
    cls.lx  = dir_x;
    cls.ly  = dir_y;
    cls.lz  = dir_z;
    cls.px  = pos_x;
    cls.py  = pos_y;
    cls.pz  = pos_z;
    cls.deg = (dir_x == '0) && (dir_z == '0);
    cls.mh  = mh;
    cls.m3  = (mh > ay) ? mh : ay;
  end

  assign in_ready   = !hold_valid || push_ready;
  assign push_valid = hold_valid;
  assign push_item  = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
    end else if (push_ready) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold <= cls;
    end
  end

endmodule

`default_nettype wire

[rtl/lav_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module lav_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire lav_pkg::item_t push_item,
  output logic                pop_valid,
  input  wire logic           pop,
  output lav_pkg::item_t      pop_item
);
  import lav_pkg::*;

  item_t       mem [2];
  logic        wptr, rptr;
  logic [1:0]  count;
  logic        do_push, do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_item   = mem[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= ~wptr;
      end
      if (do_pop) begin
        rptr <= ~rptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

[rtl/lav_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module lav_back #(
  parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  output logic                q_pop,
  input  wire lav_pkg::item_t q_item,
  output logic                bank_valid,
  input  wire logic           bank_ready,
  output lav_pkg::bank_t      bank
);
  import lav_pkg::*;

  localparam int NUM_W = WORD_W + FRAC_BITS;
  localparam int DCW   = $clog2(FRAC_BITS + 2);
  localparam logic [DCW-1:0] DSTEPS = DCW'(FRAC_BITS + 1);

  back_state_t state, state_next;

  // Item registers.
  logic [WORD_W-1:0] lx, ly, lz, px, py, pz, m3r;
  logic              deg;
  logic signed [WORD_W:0] v0, v1, v2;
  logic [WORD_W-1:0] m;
  logic              pass2;

  // Shared multiplier.
  logic signed [WORD_W:0]     mul_a, mul_b;
  logic signed [2*WORD_W+1:0] prod;
  logic [2*WORD_W-1:0]        acc_sq;

  // Square root unit.
  logic [2*WORD_W-1:0] sv, sres, sbit, s_try;
  logic                sq_go;
  logic [2*WORD_W-1:0] sq_in;
  sq_dst_t             sq_to, sq_dst;
  logic [WORD_W-1:0]   n, h, d;

  // Divider.
  logic                div_go, div_neg;
  logic [NUM_W-1:0]    div_num;
  logic [WORD_W-1:0]   div_den;
  div_dst_t            div_to, ddst;
  logic [WORD_W-1:0]   dr, den;
  logic [FRAC_BITS:0]  dq;
  logic                dneg;
  logic [DCW-1:0]      dcnt;
  logic [WORD_W:0]     dtry;
  logic                dge;
  logic                drnd;
  logic [FRAC_BITS+1:0] dqm;
  logic [WORD_W-1:0]   dres;

  // Results.
  logic [WORD_W-1:0] rx, rz, ux, uy, uz, t0, t1, t2;
  logic [3:0]                 tc;
  logic signed [2*WORD_W+1:0] tacc, tsum, traw0, traw1, traw2;

  logic [WORD_W:0]     mag_v0, mag_v2;
  logic [2*WORD_W+1:0] mag_prod;
  logic                in_rng;

  function automatic logic [WORD_W-1:0] fin_t(input logic signed [2*WORD_W+1:0] s);
    logic signed [2*WORD_W+2:0] rs;
    logic signed [2*WORD_W+2:0] ng;
    rs = ($signed({s[2*WORD_W+1], s}) + ((2*WORD_W+3)'(1) <<< (FRAC_BITS - 1)))
         >>> FRAC_BITS;
    ng = -rs;
    if (ng > (2*WORD_W+3)'(64'sh7FFF_FFFF)) begin
      fin_t = {1'b0, {(WORD_W-1){1'b1}}};
    end else if (ng < -(2*WORD_W+3)'(64'sh8000_0000)) begin
      fin_t = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      fin_t = ng[WORD_W-1:0];
    end
  endfunction

  assign mag_v0   = v0[WORD_W] ? -v0 : v0;
  assign mag_v2   = v2[WORD_W] ? -v2 : v2;
  assign mag_prod = prod[2*WORD_W+1] ? -prod : prod;
  assign in_rng   = (m[WORD_W-1:29] == (WORD_W-29)'(1));
  assign s_try    = sres + sbit;
  assign dtry     = {dr, dq[FRAC_BITS]};
  assign dge      = (dtry >= {1'b0, den});
  assign drnd     = ({dr, 1'b0} >= {1'b0, den});
  assign dqm      = {1'b0, dq} + (FRAC_BITS+2)'(drnd);
  assign dres     = dneg ? -WORD_W'(dqm) : WORD_W'(dqm);
  assign tsum     = tacc + prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    bank_valid = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    sq_go      = 1'b0;
    sq_in      = acc_sq + prod[2*WORD_W-1:0];
    sq_to      = SQ_N;
    div_go     = 1'b0;
    div_num    = '0;
    div_neg    = 1'b0;
    div_den    = d;
    div_to     = DST_RX;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = q_item.deg ? S_TDOT : S_PRE;
        end
      end
      S_PRE: begin
        if (in_rng) begin
          state_next = S_SQA;
        end
      end
      S_SQA: begin
        mul_a      = v0;
        mul_b      = v0;
        state_next = S_SQB;
      end
      S_SQB: begin
        mul_a      = v2;
        mul_b      = v2;
        state_next = S_SQC;
      end
      S_SQC: begin
        sq_go      = 1'b1;
        sq_to      = pass2 ? SQ_H : SQ_N;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        if (sbit == '0) begin
          unique case (sq_dst)
            SQ_N: begin
              div_go     = 1'b1;
              div_to     = DST_RX;
              div_num    = NUM_W'({mag_v2[WORD_W-2:0], {FRAC_BITS{1'b0}}});
              div_neg    = v2[WORD_W];
              div_den    = sres[WORD_W-1:0];
              state_next = S_DIV;
            end
            SQ_H: begin
              state_next = S_HSQA;
            end
            SQ_D: begin
              div_go     = 1'b1;
              div_to     = DST_UY;
              div_num    = {h, {FRAC_BITS{1'b0}}};
              div_den    = sres[WORD_W-1:0];
              state_next = S_DIV;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_HSQA: begin
        mul_a      = {1'b0, h};
        mul_b      = {1'b0, h};
        state_next = S_HSQB;
      end
      S_HSQB: begin
        mul_a      = v1;
        mul_b      = v1;
        state_next = S_HSQC;
      end
      S_HSQC: begin
        sq_go      = 1'b1;
        sq_to      = SQ_D;
        state_next = S_SQRT;
      end
      S_DIV: begin
        if (dcnt == DCW'(1)) begin
          state_next = S_DRND;
        end
      end
      S_DRND: begin
        unique case (ddst)
          DST_RX: begin
            div_go     = 1'b1;
            div_to     = DST_RZ;
            div_num    = NUM_W'({mag_v0[WORD_W-2:0], {FRAC_BITS{1'b0}}});
            div_neg    = !v0[WORD_W];
            div_den    = n;
            state_next = S_DIV;
          end
          DST_RZ:  state_next = S_PRE;
          DST_UY:  state_next = S_MX;
          DST_UX:  state_next = S_MZ;
          DST_UZ:  state_next = S_TDOT;
          default: state_next = S_IDLE;
        endcase
      end
      S_MX: begin
        mul_a      = {rz[WORD_W-1], rz};
        mul_b      = v1;
        state_next = S_MXB;
      end
      S_MXB: begin
        div_go     = 1'b1;
        div_to     = DST_UX;
        div_num    = mag_prod[NUM_W-1:0];
        div_neg    = prod[2*WORD_W+1];
        state_next = S_DIV;
      end
      S_MZ: begin
        mul_a      = {rx[WORD_W-1], rx};
        mul_b      = v1;
        state_next = S_MZB;
      end
      S_MZB: begin
        div_go     = 1'b1;
        div_to     = DST_UZ;
        div_num    = mag_prod[NUM_W-1:0];
        div_neg    = !prod[2*WORD_W+1];
        state_next = S_DIV;
      end
      S_TDOT: begin
        // Products are issued in dot order: right, up, then direction with the position.
        case (tc)
          4'd0:    begin mul_a = {rx[WORD_W-1], rx}; mul_b = {px[WORD_W-1], px}; end
          4'd1:    begin mul_a = '0;                 mul_b = {py[WORD_W-1], py}; end
          4'd2:    begin mul_a = {rz[WORD_W-1], rz}; mul_b = {pz[WORD_W-1], pz}; end
          4'd3:    begin mul_a = {ux[WORD_W-1], ux}; mul_b = {px[WORD_W-1], px}; end
          4'd4:    begin mul_a = {uy[WORD_W-1], uy}; mul_b = {py[WORD_W-1], py}; end
          4'd5:    begin mul_a = {uz[WORD_W-1], uz}; mul_b = {pz[WORD_W-1], pz}; end
          4'd6:    begin mul_a = {lx[WORD_W-1], lx}; mul_b = {px[WORD_W-1], px}; end
          4'd7:    begin mul_a = {ly[WORD_W-1], ly}; mul_b = {py[WORD_W-1], py}; end
          4'd8:    begin mul_a = {lz[WORD_W-1], lz}; mul_b = {pz[WORD_W-1], pz}; end
          default: begin mul_a = '0;                 mul_b = '0;                 end
        endcase
        if (tc == 4'd9) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        bank_valid = 1'b1;
        if (bank_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;

    if (sq_go) begin
      sv     <= sq_in;
      sres   <= '0;
      sbit   <= {2'b01, {(2*WORD_W-2){1'b0}}};
      sq_dst <= sq_to;
    end

    if (div_go) begin
      dr   <= {1'b0, div_num[NUM_W-1:FRAC_BITS+1]};
      dq   <= div_num[FRAC_BITS:0];
      den  <= div_den;
      dneg <= div_neg;
      ddst <= div_to;
      dcnt <= DSTEPS;
    end

    case (state)
      S_IDLE: begin
        lx    <= q_item.lx;
        ly    <= q_item.ly;
        lz    <= q_item.lz;
        px    <= q_item.px;
        py    <= q_item.py;
        pz    <= q_item.pz;
        deg   <= q_item.deg;
        m3r   <= q_item.m3;
        m     <= q_item.mh;
        v0    <= {q_item.lx[WORD_W-1], q_item.lx};
        v2    <= {q_item.lz[WORD_W-1], q_item.lz};
        pass2 <= 1'b0;
        rx    <= '0;
        rz    <= '0;
        ux    <= '0;
        uy    <= '0;
        uz    <= '0;
        tc    <= '0;
        tacc  <= '0;
      end
      S_PRE: begin
        // One bit of scaling per cycle; arithmetic right shifts floor exactly.
        if (m[WORD_W-1:30] != '0) begin
          m  <= m >> 1;
          v0 <= v0 >>> 1;
          v1 <= v1 >>> 1;
          v2 <= v2 >>> 1;
        end else if (!m[29]) begin
          m  <= m << 1;
          v0 <= v0 <<< 1;
          v1 <= v1 <<< 1;
          v2 <= v2 <<< 1;
        end
      end
      S_SQB, S_HSQB: begin
        acc_sq <= prod[2*WORD_W-1:0];
      end
      S_SQRT: begin
        if (sbit != '0) begin
          if (sv >= s_try) begin
            sv   <= sv - s_try;
            sres <= (sres >> 1) + sbit;
          end else begin
            sres <= sres >> 1;
          end
          sbit <= sbit >> 2;
        end else begin
          case (sq_dst)
            SQ_N:    n <= sres[WORD_W-1:0];
            SQ_H:    h <= sres[WORD_W-1:0];
            default: d <= sres[WORD_W-1:0];
          endcase
        end
      end
      S_DIV: begin
        dr   <= dge ? WORD_W'(dtry - {1'b0, den}) : dtry[WORD_W-1:0];
        dq   <= {dq[FRAC_BITS-1:0], dge};
        dcnt <= dcnt - DCW'(1);
      end
      S_DRND: begin
        case (ddst)
          DST_RX: rx <= dres;
          DST_RZ: begin
            rz    <= dres;
            pass2 <= 1'b1;
            m     <= m3r;
            v0    <= {lx[WORD_W-1], lx};
            v1    <= {ly[WORD_W-1], ly};
            v2    <= {lz[WORD_W-1], lz};
          end
          DST_UY: uy <= dres;
          DST_UX: ux <= dres;
          default: begin
            uz   <= dres;
            tc   <= '0;
            tacc <= '0;
          end
        endcase
      end
      S_TDOT: begin
        tc <= tc + 4'd1;
        if (tc != 4'd0) begin
          case (tc)
            4'd3: begin traw0 <= tsum; tacc <= '0; end
            4'd6: begin traw1 <= tsum; tacc <= '0; end
            4'd9: begin traw2 <= tsum; tacc <= '0; end
            default: tacc <= tsum;
          endcase
        end
      end
      S_FIN: begin
        t0 <= fin_t(traw0);
        t1 <= fin_t(traw1);
        t2 <= fin_t(traw2);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    bank.rx  = rx;
    bank.rz  = rz;
    bank.ux  = ux;
    bank.uy  = uy;
    bank.uz  = uz;
    bank.lx  = lx;
    bank.ly  = ly;
    bank.lz  = lz;
    bank.t0  = t0;
    bank.t1  = t1;
    bank.t2  = t2;
    bank.deg = deg;
  end

endmodule

`default_nettype wire

[rtl/lav_emit.sv]
`timescale 1ns / 1ps
`default_nettype none

module lav_emit (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       bank_valid,
  output logic                            bank_ready,
  input  wire lav_pkg::bank_t             bank_in,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [1:0]                      row_index,
  output logic [lav_pkg::WORD_W-1:0]      col0,
  output logic [lav_pkg::WORD_W-1:0]      col1,
  output logic [lav_pkg::WORD_W-1:0]      col2,
  output logic                            last_row,
  output logic                            degenerate
);
  import lav_pkg::*;

  bank_t      bank;
  logic       busy;
  logic [1:0] row;

  assign bank_ready = !busy || (out_ready && row == ROW_LAST);
  assign out_valid  = busy;
  assign row_index  = row;
  assign last_row   = (row == ROW_LAST);
  assign degenerate = bank.deg;

  always_comb begin
    case (row)
      2'd0:    begin col0 = bank.rx; col1 = bank.ux; col2 = bank.lx; end
      2'd1:    begin col0 = '0;      col1 = bank.uy; col2 = bank.ly; end
      2'd2:    begin col0 = bank.rz; col1 = bank.uz; col2 = bank.lz; end
      default: begin col0 = bank.t0; col1 = bank.t1; col2 = bank.t2; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      row  <= 2'd0;
    end else if (bank_valid && bank_ready) begin
      busy <= 1'b1;
      row  <= 2'd0;
    end else if (busy && out_ready) begin
      if (row == ROW_LAST) begin
        busy <= 1'b0;
      end else begin
        row <= row + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (bank_valid && bank_ready) begin
      bank <= bank_in;
    end
  end

endmodule

`default_nettype wire

[rtl/look_at_view_matrix.sv]
// The iterative square root (three uses) and divider (five uses) set the time from an accepted word
// to its first row. Degenerate directions skip both. Rows leave one per cycle while out_ready is high.
// Throughput: one word per back-end pass; a two-entry queue and a row bank keep intake and output going.
// Reset: synchronous, active high; clears handshake and sequencer state only, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

// Look-at view matrix builder. The front end registers each word and flags a
// direction with no horizontal part as degenerate. The back end scales the
// direction by powers of two, takes integer square roots and rounded
// quotients for the right and up vectors, then forms the three translation
// dot products with a shared multiplier. The emitter streams the four rows
// while the back end already works on the next queued word.
module look_at_view_matrix #(
  parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic signed [lav_pkg::WORD_W-1:0] dir_x,
  input  wire logic signed [lav_pkg::WORD_W-1:0] dir_y,
  input  wire logic signed [lav_pkg::WORD_W-1:0] dir_z,
  input  wire logic signed [lav_pkg::WORD_W-1:0] pos_x,
  input  wire logic signed [lav_pkg::WORD_W-1:0] pos_y,
  input  wire logic signed [lav_pkg::WORD_W-1:0] pos_z,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [1:0]                            row_index,
  output logic signed [lav_pkg::WORD_W-1:0]     col0,
  output logic signed [lav_pkg::WORD_W-1:0]     col1,
  output logic signed [lav_pkg::WORD_W-1:0]     col2,
  output logic                                  last_row,
  output logic                                  degenerate
);
  import lav_pkg::*;

  logic  push_valid, push_ready;
  item_t push_item;
  logic  pop_valid, pop;
  item_t pop_item;
  logic  bank_valid, bank_ready;
  bank_t bank;
  logic [WORD_W-1:0] c0, c1, c2;

  // The front end takes a new word whenever its holding register drains.
  lav_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .dir_x      (dir_x),
    .dir_y      (dir_y),
    .dir_z      (dir_z),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  lav_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_item   (pop_item)
  );

  lav_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (pop_valid),
    .q_pop      (pop),
    .q_item     (pop_item),
    .bank_valid (bank_valid),
    .bank_ready (bank_ready),
    .bank       (bank)
  );

  // The emitter can take the next matrix in the same cycle its last row leaves.
  lav_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .bank_valid (bank_valid),
    .bank_ready (bank_ready),
    .bank_in    (bank),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .row_index  (row_index),
    .col0       (c0),
    .col1       (c1),
    .col2       (c2),
    .last_row   (last_row),
    .degenerate (degenerate)
  );

  assign col0 = c0;
  assign col1 = c1;
  assign col2 = c2;

`ifndef SYNTHESIS
  // Rows of one matrix leave in order.
  a_row_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_row) |=>
      (out_valid && row_index == $past(row_index) + 2'd1))
    else $error("row order broken inside a matrix");

  // The degenerate flag belongs to the whole matrix.
  a_deg_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_row) |=> $stable(degenerate))
    else $error("degenerate flag changed inside a matrix");

  // A degenerate basis has zero right and up columns.
  a_deg_basis: assert property (@(posedge clk) disable iff (rst)
    (out_valid && degenerate && !last_row) |-> (col0 == '0 && col1 == '0))
    else $error("degenerate basis not zero");

  // With a zero basis the first two translation terms vanish.
  a_deg_trans: assert property (@(posedge clk) disable iff (rst)
    (out_valid && degenerate && last_row) |-> (col0 == '0 && col1 == '0))
    else $error("degenerate translation not zero");
`endif

endmodule

`default_nettype wire
